@@ design/lni_pkg.sv @@
package lni_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_NOISE_ENABLE  = 3'd0;
   localparam logic [2:0] REG_NOISE_BITS    = 3'd1;
   localparam logic [2:0] REG_JITTER_ENABLE = 3'd2;
   localparam logic [2:0] REG_JITTER_US     = 3'd3;
   localparam logic [2:0] REG_RESOLUTION_MS = 3'd4;
   localparam logic [2:0] REG_SEED          = 3'd5;

   // Request kinds carried on tuser.
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_TIME  = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int PIXEL_W = 8;
   localparam int TIME_W  = 40;
   localparam int WORK_W  = TIME_W + 1;
   localparam int DATA_W  = 48;

   localparam int NBITS_W  = 4;
   localparam int JITTER_W = 14;
   localparam int RES_W    = 10;
   localparam int RAND_W   = 15;

   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;

   // Remainder unit: 41-bit dividend, divisor up to 1023 * 1000.
   localparam int DVD_W = WORK_W;
   localparam int DVS_W = 20;
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [DVS_W-1:0] US_PER_MS = DVS_W'(1000);

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   typedef struct packed {
      logic        load;
      logic        advance;
      logic [31:0] seed;
   } lcg_ctl_type;

endpackage

@@ design/lni_lcg.sv @@
module lni_lcg
   import lni_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lcg_ctl_type       ctl,
   output logic [RAND_W-1:0] rand_out
);

   logic [31:0] state_ff;
   logic [31:0] state_in;

   always_comb begin
      priority if (ctl.load) begin
         state_in = ctl.seed;
      end else if (ctl.advance) begin
         state_in = state_ff * LCG_MUL + LCG_ADD;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rand_out = state_ff[30:16];

endmodule

@@ design/lni_divider.sv @@
module lni_divider
   import lni_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W:0]   cand;

   // One dividend bit per cycle, most significant first; only the
   // remainder is kept.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cand    = {rem_ff, dvd_ff[DVD_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cand >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(cand - {1'b0, dvs_ff});
         end else begin
            rem_in = cand[DVS_W-1:0];
         end
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

@@ design/lcg_noise_injector.sv @@
// Dither and jitter injector driven by one 32-bit linear congruential generator.
// A pixel request (tuser 0) is accepted and, when noise is enabled, noised and
// clamped; it passes through the pixel state and the output state before its
// response is registered. A time request (tuser 1) with jitter off goes from
// acceptance straight to the output state; with jitter on it makes one pass
// through the bit-serial remainder unit for the jitter modulus and, when the
// resolution is nonzero, a second pass for quantization. Each pass steps through
// the 41-bit dividend bit by bit and then signals done. The block takes one
// request at a time; it accepts the next one while the previous response still
// waits in the output register, and a stalled response holds the block once the
// next one is done.
// Writing the seed register reloads the generator.
module lcg_noise_injector
   import lni_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // pixel_in[7:0], time_in_us[47:8]
   input  logic                   req_tuser,   // mode
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // pixel_out[7:0], time_out_us[47:8]
   output logic                   rsp_tlast,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PIX    = 3'd1;
   localparam logic [2:0] ST_JSTART = 3'd2;
   localparam logic [2:0] ST_JWAIT  = 3'd3;
   localparam logic [2:0] ST_QSTART = 3'd4;
   localparam logic [2:0] ST_QWAIT  = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]          seq_ff, seq_in;
   logic                mode_ff, mode_in;
   logic [PIXEL_W-1:0]  pix_ff, pix_in;
   logic [WORK_W-1:0]   time_ff, time_in;
   logic                last_ff, last_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  rsp_pix_ff, rsp_pix_in;
   logic [TIME_W-1:0]   rsp_time_ff, rsp_time_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                noise_en_ff;
   logic [NBITS_W-1:0]  noise_bits_ff;
   logic                jitter_en_ff;
   logic [JITTER_W-1:0] jitter_us_ff;
   logic [RES_W-1:0]    res_ms_ff;

   logic                accept;
   logic [RAND_W-1:0]   rand_val;
   lcg_ctl_type         lcg_ctl;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [15:0]         mask_wide;
   logic [RAND_W-1:0]   mask;
   logic signed [16:0]  noise;
   logic signed [17:0]  pix_sum;
   logic [PIXEL_W-1:0]  pix_noised;
   logic signed [16:0]  jitter;
   logic [WORK_W-1:0]   time_abs;
   logic [WORK_W-1:0]   rem_ext;
   logic [TIME_W-1:0]   time_sat;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (seq_ff == ST_IDLE) && !reset;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_en_ff   <= 1'b1;
         noise_bits_ff <= NBITS_W'(2);
         jitter_en_ff  <= 1'b1;
         jitter_us_ff  <= JITTER_W'(100);
         res_ms_ff     <= RES_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_NOISE_ENABLE:  noise_en_ff   <= csr_wdata[0];
            REG_NOISE_BITS:    noise_bits_ff <= csr_wdata[NBITS_W-1:0];
            REG_JITTER_ENABLE: jitter_en_ff  <= csr_wdata[0];
            REG_JITTER_US:     jitter_us_ff  <= csr_wdata[JITTER_W-1:0];
            REG_RESOLUTION_MS: res_ms_ff     <= csr_wdata[RES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign lcg_ctl.load    = csr_we && (csr_index == REG_SEED);
   assign lcg_ctl.seed    = csr_wdata;
   assign lcg_ctl.advance = accept &&
                            (((req_tuser == MODE_PIXEL) && noise_en_ff) ||
                             ((req_tuser == MODE_TIME) && jitter_en_ff));

   lni_lcg u_lcg (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lcg_ctl),
      .rand_out (rand_val)
   );

   lni_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Pixel noise: (r & mask) - (mask >> 1), then clamp to a byte.
   always_comb begin
      mask_wide = (16'd1 << noise_bits_ff) - 16'd1;
      mask      = mask_wide[RAND_W-1:0];
      noise     = $signed({2'b00, rand_val & mask}) - $signed({3'b000, mask[RAND_W-1:1]});
      pix_sum   = $signed({10'd0, pix_ff}) + $signed({noise[16], noise});
      if (pix_sum < 0) begin
         pix_noised = '0;
      end else if (pix_sum > 18'sd255) begin
         pix_noised = 8'd255;
      end else begin
         pix_noised = pix_sum[PIXEL_W-1:0];
      end
   end

   assign jitter   = $signed({2'b00, div_rsp.remainder[RAND_W-1:0]})
                     - $signed({3'b000, jitter_us_ff});
   assign time_abs = time_ff[WORK_W-1] ? (~time_ff + WORK_W'(1)) : time_ff;
   assign rem_ext  = WORK_W'(div_rsp.remainder);

   always_comb begin
      if (time_ff[WORK_W-1] != time_ff[WORK_W-2]) begin
         time_sat = time_ff[WORK_W-1] ? {1'b1, {(TIME_W-1){1'b0}}}
                                      : {1'b0, {(TIME_W-1){1'b1}}};
      end else begin
         time_sat = time_ff[TIME_W-1:0];
      end
   end

   always_comb begin
      seq_in       = seq_ff;
      mode_in      = mode_ff;
      pix_in       = pix_ff;
      time_in      = time_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_last_in  = rsp_last_ff;
      div_req.start    = 1'b0;
      div_req.dividend = time_abs;
      div_req.divisor  = DVS_W'(res_ms_ff) * US_PER_MS;

      unique case (seq_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_tuser;
               pix_in  = req_tdata[PIXEL_W-1:0];
               time_in = {req_tdata[DATA_W-1], req_tdata[DATA_W-1:PIXEL_W]};
               last_in = req_tlast;
               if (req_tuser == MODE_PIXEL) begin
                  seq_in = ST_PIX;
               end else if (jitter_en_ff) begin
                  seq_in = ST_JSTART;
               end else begin
                  seq_in = ST_OUT;
               end
            end
         end
         ST_PIX: begin
            if (noise_en_ff) begin
               pix_in = pix_noised;
            end
            seq_in = ST_OUT;
         end
         ST_JSTART: begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(rand_val);
            div_req.divisor  = DVS_W'({jitter_us_ff, 1'b1});
            seq_in = ST_JWAIT;
         end
         ST_JWAIT: begin
            if (div_rsp.done) begin
               time_in = time_ff + WORK_W'(jitter);
               seq_in  = (res_ms_ff != '0) ? ST_QSTART : ST_OUT;
            end
         end
         ST_QSTART: begin
            div_req.start = 1'b1;
            seq_in = ST_QWAIT;
         end
         ST_QWAIT: begin
            // Truncation toward zero: the remainder is of the magnitude, so it is
            // subtracted from a positive value and added to a negative one.
            if (div_rsp.done) begin
               time_in = time_ff[WORK_W-1] ? (time_ff + rem_ext) : (time_ff - rem_ext);
               seq_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = (mode_ff == MODE_TIME) ? '0 : pix_ff;
               rsp_time_in  = (mode_ff == MODE_TIME) ? time_sat : '0;
               rsp_last_in  = last_ff;
               seq_in       = ST_IDLE;
            end
         end
         default: begin
            seq_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      pix_ff      <= pix_in;
      time_ff     <= time_in;
      last_ff     <= last_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_pix_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lni_pkg::*;

   // Indexes the block does not decode; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_B = 3'd7;

   localparam longint TIME_MAX_US = 64'sd549755813887;
   localparam longint TIME_MIN_US = -64'sd549755813888;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 40;
   localparam int HOLD_CYCLES     = 400;
   localparam int HOLD_PHASE      = 3;
   localparam int RANDOM_PHASES   = 13;
   localparam int ITEMS_PER_PHASE = 148;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [TIME_W-1:0]  time_us;
      logic               last;
   } injected_type;

   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
      logic                   mode;
      logic [PIXEL_W-1:0]     pixel;
      logic [TIME_W-1:0]      time_us;
      logic                   last;
      logic                   known;
      injected_type           want;
   } stim_row_type;

   typedef enum logic [1:0] {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, SHORT_STALLS} stall_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata  = '0;   // pixel_in[7:0], time_in_us[47:8]
   logic                   req_tuser  = 1'b0; // mode
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DATA_W-1:0]      rsp_tdata;         // pixel_out[7:0], time_out_us[47:8]
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Shadow copy of the block's settings and generator.
   logic                cfg_noise_en   = 1'b1;
   logic [NBITS_W-1:0]  cfg_noise_bits = 4'd2;
   logic                cfg_jitter_en  = 1'b1;
   logic [JITTER_W-1:0] cfg_jitter_us  = 14'd100;
   logic [RES_W-1:0]    cfg_res_ms     = 10'd1;
   logic [31:0]         lcg_state      = 32'd0;

   injected_type expected_q[$];
   stim_row_type stim_table[$];
   int           errors      = 0;
   int           idle_cycles = 0;
   int           burst_left  = 0;
   logic         hold_armed  = 1'b0;

   lcg_noise_injector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [RAND_W-1:0] lcg_draw();
      lcg_state = lcg_state * LCG_MUL + LCG_ADD;
      return lcg_state[30:16];
   endfunction

   function automatic injected_type inject_noise(logic mode, logic [PIXEL_W-1:0] pixel,
                                                 logic [TIME_W-1:0] time_us, logic last);
      injected_type      res;
      logic [RAND_W-1:0] r;
      logic [RAND_W-1:0] mask;
      int                sum;
      int                modulus;
      int                rem;
      longint            acc;
      longint            step;
      res = '0;
      res.last = last;
      if (mode == MODE_PIXEL) begin
         sum = int'(pixel);
         if (cfg_noise_en) begin
            r    = lcg_draw();
            mask = RAND_W'((16'd1 << cfg_noise_bits) - 16'd1);
            sum  = sum + int'(r & mask) - int'(mask >> 1);
            if (sum < 0) sum = 0;
            if (sum > 255) sum = 255;
         end
         res.pixel = sum[PIXEL_W-1:0];
      end else begin
         acc = longint'($signed(time_us));
         if (cfg_jitter_en) begin
            r       = lcg_draw();
            modulus = 2 * int'(cfg_jitter_us) + 1;
            rem     = int'(r) % modulus;
            acc     = acc + longint'(rem) - longint'(cfg_jitter_us);
            // Signed division truncates toward zero, as the quantizer does.
            if (cfg_res_ms != '0) begin
               step = longint'(cfg_res_ms) * 64'sd1000;
               acc  = (acc / step) * step;
            end
            if (acc > TIME_MAX_US) acc = TIME_MAX_US;
            if (acc < TIME_MIN_US) acc = TIME_MIN_US;
         end
         res.time_us = acc[TIME_W-1:0];
      end
      return res;
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] index,
                                     logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_NOISE_ENABLE:  cfg_noise_en   = data[0];
         REG_NOISE_BITS:    cfg_noise_bits = data[NBITS_W-1:0];
         REG_JITTER_ENABLE: cfg_jitter_en  = data[0];
         REG_JITTER_US:     cfg_jitter_us  = data[JITTER_W-1:0];
         REG_RESOLUTION_MS: cfg_res_ms     = data[RES_W-1:0];
         REG_SEED:          lcg_state      = data;
         default: ;
      endcase
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_W-1:0] index,
                                            logic [CSR_DATA_W-1:0] wdata);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = index;
      row.wdata = wdata;
      return row;
   endfunction

   function automatic stim_row_type item_row(logic mode, logic [PIXEL_W-1:0] pixel,
                                             logic [TIME_W-1:0] time_us, logic last);
      stim_row_type row;
      row         = '0;
      row.kind    = ROW_ITEM;
      row.mode    = mode;
      row.pixel   = pixel;
      row.time_us = time_us;
      row.last    = last;
      return row;
   endfunction

   function automatic stim_row_type known_row(logic mode, logic [PIXEL_W-1:0] pixel,
                                              logic [TIME_W-1:0] time_us, logic last,
                                              logic [PIXEL_W-1:0] want_pixel,
                                              logic [TIME_W-1:0] want_time);
      stim_row_type row;
      row              = item_row(mode, pixel, time_us, last);
      row.known        = 1'b1;
      row.want.pixel   = want_pixel;
      row.want.time_us = want_time;
      row.want.last    = last;
      return row;
   endfunction

   // Upper bits beyond a register's width are filled with junk the block must drop.
   function automatic logic [CSR_DATA_W-1:0] junk_above(int unsigned value, int width);
      return CSR_DATA_W'(($urandom << width) | value);
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      longint v;
      case ($urandom_range(0, 5))
         0: v = TIME_MAX_US - longint'($urandom_range(0, 40000));
         1: v = TIME_MIN_US + longint'($urandom_range(0, 40000));
         2: v = longint'($urandom_range(0, 4000000)) - 64'sd2000000;
         3: v = (longint'($urandom_range(0, 2000)) - 64'sd1000) * 64'sd1000000
                + longint'($urandom_range(0, 2)) - 64'sd1;
         default: v = {$urandom, $urandom};
      endcase
      return v[TIME_W-1:0];
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      apply_csr(index, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(stim_row_type row);
      injected_type pred;
      req_tvalid <= 1'b1;
      req_tuser  <= row.mode;
      req_tdata  <= {row.time_us, row.pixel};
      req_tlast  <= row.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // The predictor runs for every request so the generator stays in step.
      pred = inject_noise(row.mode, row.pixel, row.time_us, row.last);
      expected_q.push_back(row.known ? row.want : pred);
   endtask

   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_idle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      bit                 prev_item;
      int                 phase;
      int                 n;
      logic               mode;
      logic [PIXEL_W-1:0] pixel;
      int unsigned        value;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings.
      stim_table.push_back(item_row(MODE_PIXEL, 8'd0, '0, 1'b0));
      stim_table.push_back(item_row(MODE_PIXEL, 8'd255, '0, 1'b1));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, '0, 1'b0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(TIME_MAX_US), 1'b0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(TIME_MIN_US), 1'b1));
      // Both modes off: values pass and the unused field reads zero.
      stim_table.push_back(csr_row(REG_NOISE_ENABLE, 32'd0));
      stim_table.push_back(csr_row(REG_JITTER_ENABLE, 32'd0));
      stim_table.push_back(known_row(MODE_PIXEL, 8'd0, 40'hFF_FFFF_FFFF, 1'b0, 8'd0, '0));
      stim_table.push_back(known_row(MODE_PIXEL, 8'd255, 40'h5A_5A5A_5A5A, 1'b1, 8'd255, '0));
      stim_table.push_back(known_row(MODE_PIXEL, 8'hA5, '0, 1'b0, 8'hA5, '0));
      stim_table.push_back(known_row(MODE_TIME, 8'hFF, TIME_W'(TIME_MAX_US), 1'b0,
                                     8'd0, TIME_W'(TIME_MAX_US)));
      stim_table.push_back(known_row(MODE_TIME, 8'h3C, TIME_W'(TIME_MIN_US), 1'b0,
                                     8'd0, TIME_W'(TIME_MIN_US)));
      stim_table.push_back(known_row(MODE_TIME, 8'd0, '1, 1'b1, 8'd0, '1));
      // An empty noise mask adds nothing, though a draw is still made.
      stim_table.push_back(csr_row(REG_NOISE_ENABLE, 32'd1));
      stim_table.push_back(csr_row(REG_NOISE_BITS, 32'd0));
      stim_table.push_back(known_row(MODE_PIXEL, 8'd77, '0, 1'b0, 8'd77, '0));
      // Zero jitter and no quantization: time passes through.
      stim_table.push_back(csr_row(REG_JITTER_ENABLE, 32'd1));
      stim_table.push_back(csr_row(REG_JITTER_US, 32'd0));
      stim_table.push_back(csr_row(REG_RESOLUTION_MS, 32'd0));
      stim_table.push_back(known_row(MODE_TIME, 8'd0, TIME_W'(64'sd12345), 1'b0,
                                     8'd0, TIME_W'(64'sd12345)));
      stim_table.push_back(known_row(MODE_TIME, 8'd0, TIME_W'(TIME_MIN_US), 1'b0,
                                     8'd0, TIME_W'(TIME_MIN_US)));
      stim_table.push_back(csr_row(REG_SEED, 32'hFFFF_FFFF));
      stim_table.push_back(csr_row(REG_NOISE_BITS, 32'd8));
      stim_table.push_back(item_row(MODE_PIXEL, 8'd0, '0, 1'b0));
      stim_table.push_back(item_row(MODE_PIXEL, 8'd255, '0, 1'b0));
      stim_table.push_back(item_row(MODE_PIXEL, 8'd128, '0, 1'b1));
      // Widest mask, widest jitter, a one-second resolution.
      stim_table.push_back(csr_row(REG_NOISE_BITS, 32'd15));
      stim_table.push_back(csr_row(REG_JITTER_US, 32'd16383));
      stim_table.push_back(csr_row(REG_RESOLUTION_MS, 32'd1000));
      stim_table.push_back(item_row(MODE_PIXEL, 8'd0, '0, 1'b0));
      stim_table.push_back(item_row(MODE_PIXEL, 8'd255, '0, 1'b0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(TIME_MAX_US), 1'b0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(-64'sd999999), 1'b0));
      // Without quantization the widest jitter can push past either end.
      stim_table.push_back(csr_row(REG_RESOLUTION_MS, 32'd0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(TIME_MAX_US), 1'b0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(TIME_MIN_US), 1'b0));
      stim_table.push_back(csr_row(REG_RESOLUTION_MS, 32'd1023));
      stim_table.push_back(csr_row(REG_UNUSED_A, 32'hFFFF_FFFF));
      stim_table.push_back(csr_row(REG_UNUSED_B, 32'h1234_5678));
      stim_table.push_back(csr_row(REG_SEED, 32'd0));
      stim_table.push_back(item_row(MODE_TIME, 8'd0, TIME_W'(64'sd1234567890), 1'b1));

      prev_item = 1'b0;
      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            if (prev_item) drain_idle();
            write_csr(stim_table[i].index, stim_table[i].wdata);
            prev_item = 1'b0;
         end else begin
            send_request(stim_table[i]);
            pace_sender();
            prev_item = 1'b1;
         end
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_idle();
         write_csr(REG_NOISE_ENABLE, junk_above(32'($urandom_range(0, 3) != 0), 1));
         case ($urandom_range(0, 5))
            0: value = 0;
            1: value = 8;
            2: value = 15;
            default: value = $urandom_range(0, 15);
         endcase
         write_csr(REG_NOISE_BITS, junk_above(value, NBITS_W));
         write_csr(REG_JITTER_ENABLE, junk_above(32'($urandom_range(0, 3) != 0), 1));
         case ($urandom_range(0, 4))
            0: value = 0;
            1: value = 1;
            2: value = 16383;
            default: value = $urandom_range(0, 16383);
         endcase
         write_csr(REG_JITTER_US, junk_above(value, JITTER_W));
         case ($urandom_range(0, 5))
            0: value = 0;
            1: value = 1;
            2: value = 1000;
            3: value = 1023;
            default: value = $urandom_range(0, 1023);
         endcase
         write_csr(REG_RESOLUTION_MS, junk_above(value, RES_W));
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, $urandom);
         if ($urandom_range(0, 4) != 0) write_csr(REG_SEED, $urandom);

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == HOLD_PHASE && n == 4) hold_armed = 1'b1;
            mode = ($urandom_range(0, 5) == 0) ? MODE_TIME : MODE_PIXEL;
            if ($urandom_range(0, 3) == 0)
               pixel = $urandom_range(0, 1) ? PIXEL_W'($urandom_range(0, 7))
                                            : PIXEL_W'($urandom_range(248, 255));
            else
               pixel = PIXEL_W'($urandom_range(0, 255));
            send_request(item_row(mode, pixel, rand_time(), ($urandom_range(0, 7) == 0)));
            pace_sender();
         end
      end

      drain_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : receiver
      stall_type pattern;
      int        run_left;
      pattern  = ALWAYS_READY;
      run_left = 0;
      forever begin
         // One long hold-off lets the block fill up and push back on requests.
         if (hold_armed) begin
            hold_armed = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (run_left == 0) begin
            pattern  = stall_type'($urandom_range(0, 3));
            run_left = $urandom_range(10, 150);
         end
         case (pattern)
            ALWAYS_READY:   rsp_tready <= 1'b1;
            COIN_FLIP:      rsp_tready <= ($urandom_range(0, 1) == 1);
            MOSTLY_STALLED: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:        rsp_tready <= ($urandom_range(0, 7) != 0);
         endcase
         run_left--;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_response
      injected_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual pixel %0d time %0d",
                     $time, rsp_tdata[7:0], $signed(rsp_tdata[47:8]));
            errors = errors + 1;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[7:0] !== want.pixel) begin
               $display("%0t: pixel_out expected %0d actual %0d",
                        $time, want.pixel, rsp_tdata[7:0]);
               errors = errors + 1;
            end
            if (rsp_tdata[47:8] !== want.time_us) begin
               $display("%0t: time_out_us expected %0d actual %0d",
                        $time, $signed(want.time_us), $signed(rsp_tdata[47:8]));
               errors = errors + 1;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_out expected %0d actual %0d",
                        $time, want.last, rsp_tlast);
               errors = errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule
